/* design/y86_pkg.sv */
// Shared constants, types and decode functions of the Y86 executor.
// Used by the controller, the datapath and the top level.
package y86_pkg;

   localparam int MEM_BYTES = 4096;
   localparam int MEM_AW    = $clog2(MEM_BYTES);
   localparam int RF_DEPTH  = 8;

   localparam logic [2:0] ESP_IDX = 3'd4;

   localparam logic [1:0] HOP_WRITE = 2'd0;
   localparam logic [1:0] HOP_READ  = 2'd1;
   localparam logic [1:0] HOP_STEP  = 2'd2;
   localparam logic [1:0] HOP_REG   = 2'd3;

   localparam logic [1:0] ST_RUN  = 2'd0;
   localparam logic [1:0] ST_HALT = 2'd1;
   localparam logic [1:0] ST_ADDR = 2'd2;
   localparam logic [1:0] ST_INV  = 2'd3;

   localparam logic [7:0] OPC_HALT  = 8'h00;
   localparam logic [7:0] OPC_NOP   = 8'h10;
   localparam logic [7:0] OPC_RRMOV = 8'h20;
   localparam logic [7:0] OPC_IRMOV = 8'h30;
   localparam logic [7:0] OPC_RMMOV = 8'h40;
   localparam logic [7:0] OPC_MRMOV = 8'h50;
   localparam logic [7:0] OPC_ADD   = 8'h60;
   localparam logic [7:0] OPC_SUB   = 8'h61;
   localparam logic [7:0] OPC_AND   = 8'h62;
   localparam logic [7:0] OPC_XOR   = 8'h63;
   localparam logic [7:0] OPC_MUL   = 8'h64;
   localparam logic [7:0] OPC_CMP   = 8'h65;
   localparam logic [7:0] OPC_JMP   = 8'h70;
   localparam logic [7:0] OPC_JLE   = 8'h71;
   localparam logic [7:0] OPC_JL    = 8'h72;
   localparam logic [7:0] OPC_JE    = 8'h73;
   localparam logic [7:0] OPC_JNE   = 8'h74;
   localparam logic [7:0] OPC_JGE   = 8'h75;
   localparam logic [7:0] OPC_JG    = 8'h76;
   localparam logic [7:0] OPC_CALL  = 8'h80;
   localparam logic [7:0] OPC_RET   = 8'h90;
   localparam logic [7:0] OPC_PUSH  = 8'hA0;
   localparam logic [7:0] OPC_POP   = 8'hB0;
   localparam logic [7:0] OPC_WRB   = 8'hD0;
   localparam logic [7:0] OPC_WRL   = 8'hD1;
   localparam logic [7:0] OPC_MOVSB = 8'hE0;

   typedef logic [4:0] cmd_type;

   localparam cmd_type C_NONE  = 5'd0;
   localparam cmd_type C_LATCH = 5'd1;
   localparam cmd_type C_DISP  = 5'd2;
   localparam cmd_type C_HCAP  = 5'd3;
   localparam cmd_type C_RCAPH = 5'd4;
   localparam cmd_type C_F0    = 5'd5;
   localparam cmd_type C_F1    = 5'd6;
   localparam cmd_type C_FB    = 5'd7;
   localparam cmd_type C_RRA   = 5'd8;
   localparam cmd_type C_RRB   = 5'd9;
   localparam cmd_type C_RRE   = 5'd10;
   localparam cmd_type C_RSP   = 5'd11;
   localparam cmd_type C_EXEC  = 5'd12;
   localparam cmd_type C_MUL   = 5'd13;
   localparam cmd_type C_CHK   = 5'd14;
   localparam cmd_type C_LOAD  = 5'd15;
   localparam cmd_type C_STORE = 5'd16;
   localparam cmd_type C_WB    = 5'd17;
   localparam cmd_type C_WB2   = 5'd18;

   typedef struct packed {
      logic [1:0] op;
      logic       running;
      logic       fault;
      logic       last;
      logic       one_byte;
      logic       is_mul;
      logic       is_mem;
      logic       is_store;
      logic       two_wr;
   } sts_type;

   typedef struct packed {
      logic [31:0] read_value;
      logic [1:0]  run_status;
      logic        terminal_valid;
      logic        terminal_is_word;
      logic [31:0] terminal_value;
      logic [31:0] program_counter;
      logic [2:0]  condition_flags;
   } res_type;

   function automatic logic [2:0] insn_len(input logic [7:0] opc);
      logic [2:0] n;
      unique case (opc)
         OPC_HALT, OPC_NOP, OPC_RET: n = 3'd1;
         OPC_RRMOV, OPC_ADD, OPC_SUB, OPC_AND, OPC_XOR, OPC_MUL, OPC_CMP,
         OPC_PUSH, OPC_POP: n = 3'd2;
         OPC_IRMOV, OPC_RMMOV, OPC_MRMOV, OPC_WRB, OPC_WRL, OPC_MOVSB: n = 3'd6;
         OPC_JMP, OPC_JLE, OPC_JL, OPC_JE, OPC_JNE, OPC_JGE, OPC_JG,
         OPC_CALL: n = 3'd5;
         default: n = 3'd0;
      endcase
      return n;
   endfunction

   function automatic logic fits(input logic [31:0] a, input logic [2:0] n);
      logic [32:0] e;
      e = {1'b0, a} + {30'd0, n};
      return e <= 33'(MEM_BYTES);
   endfunction

   function automatic logic cond_true(input logic [7:0] opc, input logic zf,
                                      input logic sf, input logic of);
      logic lt;
      logic c;
      lt = sf ^ of;
      unique case (opc)
         OPC_JMP: c = 1'b1;
         OPC_JLE: c = lt | zf;
         OPC_JL:  c = lt;
         OPC_JE:  c = zf;
         OPC_JNE: c = ~zf;
         OPC_JGE: c = ~lt;
         default: c = ~lt & ~zf;
      endcase
      return c;
   endfunction

   function automatic logic is_store_op(input logic [7:0] opc);
      return (opc == OPC_RMMOV) || (opc == OPC_CALL) || (opc == OPC_PUSH);
   endfunction

   function automatic logic is_mem_op(input logic [7:0] opc);
      return is_store_op(opc) || (opc == OPC_MRMOV) || (opc == OPC_MOVSB) ||
             (opc == OPC_WRB) || (opc == OPC_WRL) || (opc == OPC_RET) ||
             (opc == OPC_POP);
   endfunction

   function automatic logic [2:0] mem_nbytes(input logic [7:0] opc);
      return ((opc == OPC_MOVSB) || (opc == OPC_WRB)) ? 3'd1 : 3'd4;
   endfunction

endpackage

/* design/y86_if.sv */
// Handshake channel interfaces for host requests and results.
// No dependencies.
interface y86_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [11:0] address;
   logic [7:0]  write_byte;
   logic [2:0]  register_index;
   modport source(output valid, operation, address, write_byte, register_index,
                  input ready);
   modport sink(input valid, operation, address, write_byte, register_index,
                output ready);
endinterface

interface y86_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_value;
   logic [1:0]  run_status;
   logic        terminal_valid;
   logic        terminal_is_word;
   logic [31:0] terminal_value;
   logic [31:0] program_counter;
   logic [2:0]  condition_flags;
   modport source(output valid, read_value, run_status, terminal_valid,
                  terminal_is_word, terminal_value, program_counter,
                  condition_flags, input ready);
   modport sink(input valid, read_value, run_status, terminal_valid,
                terminal_is_word, terminal_value, program_counter,
                condition_flags, output ready);
endinterface

/* design/y86_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module y86_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* design/y86_ctrl.sv */
// Sequencer of the Y86 executor: walks host operations and instruction phases.
// Depends on y86_pkg; drives commands into y86_dpath.
module y86_ctrl
   import y86_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    out_free,
   input  sts_type sts,
   output logic    req_ready,
   output logic    out_load,
   output cmd_type cmd
);
   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_DISP = 5'd1;
   localparam logic [4:0] S_HCAP = 5'd2;
   localparam logic [4:0] S_RCAP = 5'd3;
   localparam logic [4:0] S_F0   = 5'd4;
   localparam logic [4:0] S_F1   = 5'd5;
   localparam logic [4:0] S_FB   = 5'd6;
   localparam logic [4:0] S_RA   = 5'd7;
   localparam logic [4:0] S_RB   = 5'd8;
   localparam logic [4:0] S_RE   = 5'd9;
   localparam logic [4:0] S_EX0  = 5'd10;
   localparam logic [4:0] S_EX   = 5'd11;
   localparam logic [4:0] S_MUL  = 5'd12;
   localparam logic [4:0] S_CHK  = 5'd13;
   localparam logic [4:0] S_LD   = 5'd14;
   localparam logic [4:0] S_ST   = 5'd15;
   localparam logic [4:0] S_WB   = 5'd16;
   localparam logic [4:0] S_WB2  = 5'd17;
   localparam logic [4:0] S_OUT  = 5'd18;

   logic [4:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = C_NONE;
      req_ready = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd      = C_LATCH;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            cmd = C_DISP;
            unique case (sts.op)
               HOP_WRITE: state_in = S_OUT;
               HOP_READ:  state_in = S_HCAP;
               HOP_REG:   state_in = S_RCAP;
               default:   state_in = sts.running ? S_F0 : S_OUT;
            endcase
         end
         S_HCAP: begin
            cmd      = C_HCAP;
            state_in = S_OUT;
         end
         S_RCAP: begin
            cmd      = C_RCAPH;
            state_in = S_OUT;
         end
         S_F0: begin
            cmd      = C_F0;
            state_in = sts.fault ? S_OUT : S_F1;
         end
         S_F1: begin
            cmd = C_F1;
            priority if (sts.fault) begin
               state_in = S_OUT;
            end else if (sts.one_byte) begin
               state_in = S_RA;
            end else begin
               state_in = S_FB;
            end
         end
         S_FB: begin
            cmd = C_FB;
            if (sts.last) begin
               state_in = S_RA;
            end
         end
         S_RA: begin
            cmd      = C_RRA;
            state_in = S_RB;
         end
         S_RB: begin
            cmd      = C_RRB;
            state_in = S_RE;
         end
         S_RE: begin
            cmd      = C_RRE;
            state_in = S_EX0;
         end
         S_EX0: begin
            cmd      = C_RSP;
            state_in = S_EX;
         end
         S_EX: begin
            cmd = C_EXEC;
            priority if (sts.is_mul) begin
               state_in = S_MUL;
            end else if (sts.is_mem) begin
               state_in = S_CHK;
            end else begin
               state_in = S_OUT;
            end
         end
         S_MUL: begin
            cmd      = C_MUL;
            state_in = S_OUT;
         end
         S_CHK: begin
            cmd = C_CHK;
            priority if (sts.fault) begin
               state_in = S_OUT;
            end else if (sts.is_store) begin
               state_in = S_ST;
            end else begin
               state_in = S_LD;
            end
         end
         S_LD: begin
            cmd = C_LOAD;
            if (sts.last) begin
               state_in = S_WB;
            end
         end
         S_ST: begin
            cmd = C_STORE;
            if (sts.last) begin
               state_in = S_WB;
            end
         end
         S_WB: begin
            cmd      = C_WB;
            state_in = sts.two_wr ? S_WB2 : S_OUT;
         end
         S_WB2: begin
            cmd      = C_WB2;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_load_returns_idle: assert property (@(posedge clock) disable iff (reset)
      out_load |=> state_ff == S_IDLE)
      else $error("result load did not return to idle");

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == S_DISP)
      else $error("accepted beat not dispatched");

   a_fetch_fault_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_F0 && sts.fault) |=> state_ff == S_OUT)
      else $error("fetch fault did not end the step");

   a_ready_no_load: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !out_load)
      else $error("accept and result load in the same cycle");
endmodule

/* design/y86_dpath.sv */
// Datapath of the Y86 executor: memories, registers, flags, ALU, multiplier.
// Depends on y86_pkg and y86_ram; driven by commands from y86_ctrl.
module y86_dpath
   import y86_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  logic [1:0]  in_operation,
   input  logic [11:0] in_address,
   input  logic [7:0]  in_write_byte,
   input  logic [2:0]  in_register_index,
   input  logic        csr_write_enable,
   input  logic [11:0] csr_write_data,
   output sts_type     sts,
   output res_type     res
);
   logic [1:0]  op_ff, op_in;
   logic [11:0] haddr_ff, haddr_in;
   logic [7:0]  hbyte_ff, hbyte_in;
   logic [2:0]  ridx_ff, ridx_in;
   logic [31:0] ip_ff, ip_in;
   logic        zf_ff, zf_in, sf_ff, sf_in, of_ff, of_in;
   logic [1:0]  stat_ff, stat_in;
   logic        started_ff, started_in;
   logic [7:0]  opc_ff, opc_in;
   logic [7:0]  ib_ff [1:5];
   logic [7:0]  ib_in [1:5];
   logic [2:0]  cnt_ff, cnt_in;
   logic [31:0] a_ff, a_in, b_ff, b_in, sp_ff, sp_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [31:0] daddr_ff, daddr_in, wd_ff, wd_in, ld_ff, ld_in;
   logic [31:0] rv_ff, rv_in, tval_ff, tval_in;
   logic        tv_ff, tv_in, tw_ff, tw_in;
   logic [RF_DEPTH-1:0] rfv_ff, rfv_in;
   logic        rfv_rd_ff;

   logic              mem_we;
   logic [MEM_AW-1:0] mem_waddr, mem_raddr;
   logic [7:0]        mem_wdata, mem_rdata;
   logic              rf_we;
   logic [2:0]        rf_waddr, rf_raddr;
   logic [31:0]       rf_wdata, rf_rdata, rf_val;

   logic [2:0]  len, l0, nbytes;
   logic [31:0] imm, alu_r;
   logic [2:0]  ra, rb;
   logic        host_ok;

   y86_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   y86_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .rd_addr (rf_raddr),
      .rd_data (rf_rdata)
   );

   assign rf_val  = rfv_rd_ff ? rf_rdata : 32'd0;
   assign len     = insn_len(opc_ff);
   assign l0      = insn_len(mem_rdata);
   assign nbytes  = mem_nbytes(opc_ff);
   assign imm     = (len == 3'd6) ? {ib_ff[5], ib_ff[4], ib_ff[3], ib_ff[2]}
                                  : {ib_ff[4], ib_ff[3], ib_ff[2], ib_ff[1]};
   assign ra      = ib_ff[1][6:4];
   assign rb      = ib_ff[1][2:0];
   assign host_ok = {20'd0, haddr_ff} < 32'(MEM_BYTES);

   always_comb begin
      op_in      = op_ff;
      haddr_in   = haddr_ff;
      hbyte_in   = hbyte_ff;
      ridx_in    = ridx_ff;
      ip_in      = ip_ff;
      zf_in      = zf_ff;
      sf_in      = sf_ff;
      of_in      = of_ff;
      stat_in    = stat_ff;
      started_in = started_ff;
      opc_in     = opc_ff;
      ib_in      = ib_ff;
      cnt_in     = cnt_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      sp_in      = sp_ff;
      prod_in    = prod_ff;
      daddr_in   = daddr_ff;
      wd_in      = wd_ff;
      ld_in      = ld_ff;
      rv_in      = rv_ff;
      tv_in      = tv_ff;
      tw_in      = tw_ff;
      tval_in    = tval_ff;
      mem_we     = 1'b0;
      mem_waddr  = MEM_AW'(daddr_ff + {29'd0, cnt_ff});
      mem_wdata  = wd_ff[{cnt_ff[1:0], 3'b000} +: 8];
      mem_raddr  = MEM_AW'(daddr_ff);
      rf_we      = 1'b0;
      rf_waddr   = ra;
      rf_wdata   = ld_ff;
      rf_raddr   = ra;
      alu_r      = 32'd0;
      sts          = '0;
      sts.op       = op_ff;
      sts.running  = stat_ff == ST_RUN;
      sts.is_mul   = opc_ff == OPC_MUL;
      sts.is_mem   = is_mem_op(opc_ff);
      sts.is_store = is_store_op(opc_ff);
      sts.two_wr   = opc_ff == OPC_POP;

      unique case (cmd)
         C_LATCH: begin
            op_in    = in_operation;
            haddr_in = in_address;
            hbyte_in = in_write_byte;
            ridx_in  = in_register_index;
            rv_in    = 32'd0;
            tv_in    = 1'b0;
            tw_in    = 1'b0;
            tval_in  = 32'd0;
         end
         C_DISP: begin
            unique case (op_ff)
               HOP_WRITE: begin
                  mem_we    = host_ok;
                  mem_waddr = MEM_AW'({20'd0, haddr_ff});
                  mem_wdata = hbyte_ff;
               end
               HOP_READ: mem_raddr = MEM_AW'({20'd0, haddr_ff});
               HOP_REG:  rf_raddr  = ridx_ff;
               default:  started_in = 1'b1;
            endcase
         end
         C_HCAP:  rv_in = host_ok ? {24'd0, mem_rdata} : 32'd0;
         C_RCAPH: rv_in = rf_val;
         C_F0: begin
            mem_raddr = MEM_AW'(ip_ff);
            if (!fits(ip_ff, 3'd1)) begin
               sts.fault = 1'b1;
               stat_in   = ST_ADDR;
            end
         end
         C_F1: begin
            opc_in       = mem_rdata;
            sts.one_byte = l0 == 3'd1;
            mem_raddr    = MEM_AW'(ip_ff + 32'd1);
            cnt_in       = 3'd1;
            priority if (l0 == 3'd0) begin
               sts.fault = 1'b1;
               stat_in   = ST_INV;
            end else if (!fits(ip_ff, l0)) begin
               sts.fault = 1'b1;
               stat_in   = ST_ADDR;
            end
         end
         C_FB: begin
            ib_in[cnt_ff] = mem_rdata;
            sts.last      = (cnt_ff + 3'd1) == len;
            mem_raddr     = MEM_AW'(ip_ff + {29'd0, cnt_ff} + 32'd1);
            cnt_in        = cnt_ff + 3'd1;
         end
         C_RRA: rf_raddr = ra;
         C_RRB: begin
            a_in     = rf_val;
            rf_raddr = rb;
         end
         C_RRE: begin
            b_in     = rf_val;
            rf_raddr = ESP_IDX;
         end
         C_RSP: sp_in = rf_val;
         C_EXEC: begin
            unique case (opc_ff)
               OPC_HALT: begin
                  stat_in = ST_HALT;
                  ip_in   = ip_ff + 32'd1;
               end
               OPC_NOP: ip_in = ip_ff + 32'd1;
               OPC_RRMOV: begin
                  rf_we    = 1'b1;
                  rf_waddr = rb;
                  rf_wdata = a_ff;
                  ip_in    = ip_ff + 32'd2;
               end
               OPC_IRMOV: begin
                  rf_we    = 1'b1;
                  rf_waddr = rb;
                  rf_wdata = imm;
                  ip_in    = ip_ff + 32'd6;
               end
               OPC_ADD, OPC_SUB, OPC_AND, OPC_XOR, OPC_CMP: begin
                  unique case (opc_ff)
                     OPC_ADD: begin
                        alu_r = a_ff + b_ff;
                        of_in = ~(a_ff[31] ^ b_ff[31]) & (a_ff[31] ^ alu_r[31]);
                     end
                     OPC_AND: begin
                        alu_r = a_ff & b_ff;
                        of_in = 1'b0;
                     end
                     OPC_XOR: begin
                        alu_r = a_ff ^ b_ff;
                        of_in = 1'b0;
                     end
                     default: begin
                        alu_r = b_ff - a_ff;
                        of_in = (a_ff[31] ^ b_ff[31]) & (b_ff[31] ^ alu_r[31]);
                     end
                  endcase
                  zf_in    = alu_r == 32'd0;
                  sf_in    = alu_r[31];
                  rf_we    = opc_ff != OPC_CMP;
                  rf_waddr = rb;
                  rf_wdata = alu_r;
                  ip_in    = ip_ff + 32'd2;
               end
               OPC_MUL: prod_in = $signed(a_ff) * $signed(b_ff);
               OPC_JMP, OPC_JLE, OPC_JL, OPC_JE, OPC_JNE, OPC_JGE, OPC_JG: begin
                  ip_in = cond_true(opc_ff, zf_ff, sf_ff, of_ff) ? imm
                                                                 : ip_ff + 32'd5;
               end
               OPC_RMMOV: begin
                  daddr_in = imm + b_ff;
                  wd_in    = a_ff;
               end
               OPC_MRMOV, OPC_MOVSB: daddr_in = imm + b_ff;
               OPC_WRB, OPC_WRL:     daddr_in = imm + a_ff;
               OPC_CALL: begin
                  daddr_in = sp_ff - 32'd4;
                  wd_in    = ip_ff + 32'd5;
               end
               OPC_PUSH: begin
                  daddr_in = sp_ff - 32'd4;
                  wd_in    = a_ff;
               end
               OPC_RET, OPC_POP: daddr_in = sp_ff;
               default: ;
            endcase
         end
         C_MUL: begin
            alu_r    = prod_ff[31:0];
            of_in    = !((&prod_ff[63:31]) || !(|prod_ff[63:31]));
            zf_in    = alu_r == 32'd0;
            sf_in    = alu_r[31];
            rf_we    = 1'b1;
            rf_waddr = rb;
            rf_wdata = alu_r;
            ip_in    = ip_ff + 32'd2;
         end
         C_CHK: begin
            cnt_in    = 3'd0;
            mem_raddr = MEM_AW'(daddr_ff);
            if (!fits(daddr_ff, nbytes)) begin
               sts.fault = 1'b1;
               stat_in   = ST_ADDR;
            end
         end
         C_LOAD: begin
            ld_in[{cnt_ff[1:0], 3'b000} +: 8] = mem_rdata;
            sts.last  = cnt_ff == (nbytes - 3'd1);
            mem_raddr = MEM_AW'(daddr_ff + {29'd0, cnt_ff} + 32'd1);
            cnt_in    = cnt_ff + 3'd1;
         end
         C_STORE: begin
            mem_we   = 1'b1;
            sts.last = cnt_ff == (nbytes - 3'd1);
            cnt_in   = cnt_ff + 3'd1;
         end
         C_WB: begin
            unique case (opc_ff)
               OPC_RET: begin
                  rf_we    = 1'b1;
                  rf_waddr = ESP_IDX;
                  rf_wdata = sp_ff + 32'd4;
                  ip_in    = ld_ff;
               end
               OPC_POP: begin
                  rf_we    = 1'b1;
                  rf_waddr = ESP_IDX;
                  rf_wdata = sp_ff + 32'd4;
                  ip_in    = ip_ff + 32'd2;
               end
               OPC_MRMOV: begin
                  rf_we = 1'b1;
                  ip_in = ip_ff + 32'd6;
               end
               OPC_MOVSB: begin
                  rf_we    = 1'b1;
                  rf_wdata = {{24{ld_ff[7]}}, ld_ff[7:0]};
                  ip_in    = ip_ff + 32'd6;
               end
               OPC_WRB: begin
                  tv_in   = 1'b1;
                  tw_in   = 1'b0;
                  tval_in = {24'd0, ld_ff[7:0]};
                  ip_in   = ip_ff + 32'd6;
               end
               OPC_WRL: begin
                  tv_in   = 1'b1;
                  tw_in   = 1'b1;
                  tval_in = ld_ff;
                  ip_in   = ip_ff + 32'd6;
               end
               OPC_RMMOV: ip_in = ip_ff + 32'd6;
               OPC_PUSH: begin
                  rf_we    = 1'b1;
                  rf_waddr = ESP_IDX;
                  rf_wdata = daddr_ff;
                  ip_in    = ip_ff + 32'd2;
               end
               OPC_CALL: begin
                  rf_we    = 1'b1;
                  rf_waddr = ESP_IDX;
                  rf_wdata = daddr_ff;
                  ip_in    = imm;
               end
               default: ;
            endcase
         end
         C_WB2: rf_we = 1'b1;
         default: ;
      endcase

      if (csr_write_enable && !started_ff) begin
         ip_in = {20'd0, csr_write_data};
      end
   end

   always_comb begin
      rfv_in = rfv_ff;
      if (rf_we) begin
         rfv_in[rf_waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ip_ff      <= 32'd0;
         zf_ff      <= 1'b0;
         sf_ff      <= 1'b0;
         of_ff      <= 1'b0;
         stat_ff    <= ST_RUN;
         started_ff <= 1'b0;
         rfv_ff     <= '0;
      end else begin
         ip_ff      <= ip_in;
         zf_ff      <= zf_in;
         sf_ff      <= sf_in;
         of_ff      <= of_in;
         stat_ff    <= stat_in;
         started_ff <= started_in;
         rfv_ff     <= rfv_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      haddr_ff  <= haddr_in;
      hbyte_ff  <= hbyte_in;
      ridx_ff   <= ridx_in;
      opc_ff    <= opc_in;
      ib_ff     <= ib_in;
      cnt_ff    <= cnt_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      sp_ff     <= sp_in;
      prod_ff   <= prod_in;
      daddr_ff  <= daddr_in;
      wd_ff     <= wd_in;
      ld_ff     <= ld_in;
      rv_ff     <= rv_in;
      tv_ff     <= tv_in;
      tw_ff     <= tw_in;
      tval_ff   <= tval_in;
      rfv_rd_ff <= rfv_ff[rf_raddr];
   end

   assign res.read_value       = rv_ff;
   assign res.run_status       = stat_ff;
   assign res.terminal_valid   = tv_ff;
   assign res.terminal_is_word = tw_ff;
   assign res.terminal_value   = tval_ff;
   assign res.program_counter  = ip_ff;
   assign res.condition_flags  = {of_ff, sf_ff, zf_ff};
endmodule

/* design/y86_instruction_executor_core.sv */
// Y86 executor top level: controller, datapath and result register.
// Depends on y86_pkg, y86_if, y86_ctrl and y86_dpath.
//
// Usage: req_chan carries one host beat (memory byte write, memory byte read,
// one instruction step, register read); rsp_chan returns exactly one result
// beat for each request, in order. csr_write_enable/csr_write_data load the
// 12-bit entry address into the program counter; this takes effect only before
// the first step after reset.
// A memory write is done in the dispatch state; a memory or register read is
// issued in dispatch and captured by a following capture state. A step runs
// through a byte-wide fetch (one instruction byte per cycle over the single
// memory read port), three register-file reads, execute, a multiply state for
// mull, and for memory instructions a bounds check, a one-byte-per-cycle load
// or store and write-back.
// A new request is taken when the sequencer is back in idle, one beat at a
// time; a result waiting in the output register does not block the next
// request, only the load of its own result. Synchronous reset clears the
// registers valid bits, flags, status and program counter; memory contents
// are undefined until written and need no clearing pass.
module y86_instruction_executor_core
   import y86_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   y86_req_if.sink     req_chan,
   y86_rsp_if.source   rsp_chan,
   input  logic        csr_write_enable,
   input  logic [11:0] csr_write_data
);
   cmd_type cmd;
   sts_type sts;
   res_type res;
   res_type res_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    out_load, out_free, req_ready;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   y86_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .out_free  (out_free),
      .sts       (sts),
      .req_ready (req_ready),
      .out_load  (out_load),
      .cmd       (cmd)
   );

   y86_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .in_operation      (req_chan.operation),
      .in_address        (req_chan.address),
      .in_write_byte     (req_chan.write_byte),
      .in_register_index (req_chan.register_index),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .sts               (sts),
      .res               (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         res_ff <= res;
      end
   end

   assign req_chan.ready            = req_ready;
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.read_value       = res_ff.read_value;
   assign rsp_chan.run_status       = res_ff.run_status;
   assign rsp_chan.terminal_valid   = res_ff.terminal_valid;
   assign rsp_chan.terminal_is_word = res_ff.terminal_is_word;
   assign rsp_chan.terminal_value   = res_ff.terminal_value;
   assign rsp_chan.program_counter  = res_ff.program_counter;
   assign rsp_chan.condition_flags  = res_ff.condition_flags;
endmodule
